/* sv/rles_pkg.sv */
package rles_pkg;

    localparam int MAX_BRIGHT_DEF   = 100;
    localparam int MIN_BRIGHT_DEF   = 0;
    localparam int STEP_DIVISOR_DEF = 20;
    localparam int CYCLE_COLORS_DEF = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd2;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_SINGLE  = 3'd1;
    localparam logic [2:0] MODE_BLINK   = 3'd2;
    localparam logic [2:0] MODE_CYCLE   = 3'd3;
    localparam logic [2:0] MODE_BREATHE = 3'd4;

    localparam int COLOR_ROWS = 9;

    localparam logic [7:0] PCT_OFF  = 8'd0;
    localparam logic [7:0] PCT_LOW  = 8'd15;
    localparam logic [7:0] PCT_HALF = 8'd50;
    localparam logic [7:0] PCT_FULL = 8'd100;

    typedef logic [7:0] t_pct_row [0:2];

    localparam t_pct_row COLOR_PCT [0:COLOR_ROWS-1] = '{
        '{PCT_OFF,  PCT_OFF,  PCT_OFF},
        '{PCT_FULL, PCT_OFF,  PCT_OFF},
        '{PCT_FULL, PCT_LOW,  PCT_OFF},
        '{PCT_FULL, PCT_HALF, PCT_OFF},
        '{PCT_OFF,  PCT_FULL, PCT_OFF},
        '{PCT_OFF,  PCT_FULL, PCT_FULL},
        '{PCT_OFF,  PCT_OFF,  PCT_FULL},
        '{PCT_FULL, PCT_OFF,  PCT_FULL},
        '{PCT_FULL, PCT_FULL, PCT_FULL}
    };

    // floor(b * 15 / 100) as b * ceil(0.15 * 2^16) >> 16, exact for 8-bit b
    localparam logic [13:0] LOW_RECIP = 14'd9831;
    localparam int          LOW_SHIFT = 16;

    function automatic logic [7:0] scale_duty(input logic [7:0] pct, input logic [7:0] bright);
        logic [21:0] prod;
        logic [7:0]  duty;
        prod = bright * LOW_RECIP;
        unique case (pct)
            PCT_FULL: duty = bright;
            PCT_HALF: duty = bright >> 1;
            PCT_LOW:  duty = 8'(prod >> LOW_SHIFT);
            default:  duty = 8'd0;
        endcase
        return duty;
    endfunction

endpackage

/* sv/rgb_light_effect_sequencer.sv */
// Channel   Dir  Handshake                  Payload
// tick      in   i_valid / o_ready          i_tick_valid
// result    out  o_valid / i_ready          o_red_duty, o_green_duty, o_blue_duty, o_stepped
// config    in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One beat per cycle unless stalled; a result is registered the cycle after its acceptance.
// Tick counting, effect step and duty scaling are one pass from the state registers.
// The divided period is formed on a period write by one reciprocal multiply.
// Synchronous active-low reset clears state and output valid, not the duty/step registers.
// A held result stalls the tick channel only when it is not taken in the same cycle.
module rgb_light_effect_sequencer #(
    parameter int MAX_BRIGHT   = rles_pkg::MAX_BRIGHT_DEF,
    parameter int MIN_BRIGHT   = rles_pkg::MIN_BRIGHT_DEF,
    parameter int STEP_DIVISOR = rles_pkg::STEP_DIVISOR_DEF,
    parameter int CYCLE_COLORS = rles_pkg::CYCLE_COLORS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_tick_valid,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [7:0]                     o_red_duty,
    output logic [7:0]                     o_green_duty,
    output logic [7:0]                     o_blue_duty,
    output logic                           o_stepped,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rles_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rles_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rles_pkg::*;

    localparam logic [7:0] MAX_B    = 8'(MAX_BRIGHT);
    localparam logic [7:0] MIN_B    = 8'(MIN_BRIGHT);
    localparam logic [7:0] DELTA    = 8'(MAX_BRIGHT / STEP_DIVISOR);
    localparam logic [8:0] MIN_PLUS = 9'(MIN_BRIGHT + MAX_BRIGHT / STEP_DIVISOR);
    localparam logic [3:0] N_COLORS = 4'(CYCLE_COLORS);

    localparam int          DIV_SH = 16 + $clog2(STEP_DIVISOR);
    localparam longint      DIV_MV = ((64'd1 << DIV_SH) + STEP_DIVISOR - 1) / STEP_DIVISOR;
    localparam logic [16:0] DIV_M  = 17'(DIV_MV);

    logic [2:0]  r_mode;
    logic [15:0] r_period;
    logic [15:0] r_period_div;
    logic [15:0] r_tick_count, n_tick_count;
    logic [7:0]  r_ramp, n_ramp;
    logic        r_rising, n_rising;
    logic        r_low_seen, n_low_seen;
    logic [3:0]  r_color, n_color;
    logic [7:0]  r_bright, n_bright;
    logic        r_out_valid;
    logic [7:0]  r_red, r_green, r_blue;
    logic        r_stepped, n_stepped;

    logic        in_accept;
    logic        cfg_accept;
    logic [32:0] div_prod;
    logic [16:0] tick_next;
    logic [15:0] eff_period;
    logic [8:0]  ramp_sum;
    t_pct_row    pct;

    function automatic logic [3:0] wrap_color(input logic [3:0] c);
        logic [3:0] v;
        v = c;
        for (int k = 0; k < 8; k++) begin
            if (v >= N_COLORS) begin
                v = v - N_COLORS;
            end
        end
        return v;
    endfunction

    assign o_ready     = !r_out_valid || i_ready;
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_valid && o_ready;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;

    assign o_valid      = r_out_valid;
    assign o_red_duty   = r_red;
    assign o_green_duty = r_green;
    assign o_blue_duty  = r_blue;
    assign o_stepped    = r_stepped;

    assign div_prod = i_cfg_data * DIV_M;

    always_comb begin
        n_tick_count = r_tick_count;
        n_ramp       = r_ramp;
        n_rising     = r_rising;
        n_low_seen   = r_low_seen;
        n_color      = r_color;
        n_bright     = r_bright;
        n_stepped    = 1'b0;
        ramp_sum     = '0;
        tick_next    = {1'b0, r_tick_count} + 17'd1;
        eff_period   = (r_mode == MODE_CYCLE || r_mode == MODE_BREATHE) ? r_period_div : r_period;

        if (i_tick_valid) begin
            if (tick_next >= {1'b0, eff_period}) begin
                n_tick_count = '0;
                n_stepped    = 1'b1;
                unique case (r_mode)
                    MODE_SINGLE: begin
                        n_bright = MAX_B;
                    end
                    MODE_BLINK: begin
                        n_rising = !r_rising;
                        n_ramp   = n_rising ? MAX_B : 8'd0;
                        n_bright = n_ramp;
                    end
                    MODE_CYCLE, MODE_BREATHE: begin
                        if ({1'b0, r_ramp} >= 9'(MAX_BRIGHT)) begin
                            n_rising = 1'b0;
                            n_ramp   = MAX_B;
                        end else if ({1'b0, r_ramp} <= 9'(MIN_BRIGHT)) begin
                            n_rising   = 1'b1;
                            n_ramp     = MIN_B;
                            n_low_seen = 1'b1;
                        end
                        if (n_rising) begin
                            ramp_sum = {1'b0, n_ramp} + {1'b0, DELTA};
                            n_ramp   = ramp_sum[8] ? 8'hFF : ramp_sum[7:0];
                        end else if ({1'b0, n_ramp} >= MIN_PLUS) begin
                            n_ramp = n_ramp - DELTA;
                        end else begin
                            n_ramp = MIN_B;
                        end
                        if (r_mode == MODE_CYCLE) begin
                            if (n_low_seen && n_rising) begin
                                n_low_seen = 1'b0;
                                n_color    = r_color + 4'd1;
                            end
                            n_color = wrap_color(n_color);
                            if (n_color == 4'd0) begin
                                n_color = 4'd1;
                            end
                        end
                        n_bright = n_ramp;
                    end
                    default: begin
                        n_color  = 4'd0;
                        n_bright = 8'd0;
                    end
                endcase
            end else begin
                n_tick_count = tick_next[15:0];
            end
        end

        if (n_color < 4'(COLOR_ROWS)) begin
            pct = COLOR_PCT[n_color];
        end else begin
            pct = '{PCT_OFF, PCT_OFF, PCT_OFF};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_period     <= '0;
            r_period_div <= '0;
            r_tick_count <= '0;
            r_ramp       <= '0;
            r_rising     <= 1'b0;
            r_low_seen   <= 1'b0;
            r_color      <= '0;
            r_bright     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_tick_count <= n_tick_count;
                r_ramp       <= n_ramp;
                r_rising     <= n_rising;
                r_low_seen   <= n_low_seen;
                r_color      <= n_color;
                r_bright     <= n_bright;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid  <= 1'b0;
            end
            if (cfg_accept) begin
                unique case (i_cfg_index)
                    CFG_MODE: begin
                        r_mode <= i_cfg_data[2:0];
                    end
                    CFG_COLOR: begin
                        r_color <= i_cfg_data[3:0];
                    end
                    CFG_PERIOD: begin
                        r_period     <= i_cfg_data;
                        r_period_div <= 16'(div_prod >> DIV_SH);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_red     <= scale_duty(pct[0], n_bright);
            r_green   <= scale_duty(pct[1], n_bright);
            r_blue    <= scale_duty(pct[2], n_bright);
            r_stepped <= n_stepped;
        end
    end

    a_no_tick_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !i_tick_valid |=> !o_stepped)
        else $error("step reported for a beat without a tick");

    a_step_restarts_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_tick_valid |=> (o_stepped == (r_tick_count == 16'd0)))
        else $error("tick counter disagrees with reported step");

    a_held_result_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("tick accepted while result held");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_valid)
        else $error("accepted beat produced no result");

endmodule

/* test/rles_duty_checker.sv */
`timescale 1ns / 1ps

module rles_duty_checker #(
    parameter int MAX_BRIGHT   = rles_pkg::MAX_BRIGHT_DEF,
    parameter int MIN_BRIGHT   = rles_pkg::MIN_BRIGHT_DEF,
    parameter int STEP_DIVISOR = rles_pkg::STEP_DIVISOR_DEF,
    parameter int CYCLE_COLORS = rles_pkg::CYCLE_COLORS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_tick_vld,
    input  logic                            i_tick_rdy,
    input  logic                            i_tick,
    input  logic                            i_res_vld,
    input  logic                            i_res_rdy,
    input  logic [7:0]                      i_red,
    input  logic [7:0]                      i_green,
    input  logic [7:0]                      i_blue,
    input  logic                            i_stepped,
    input  logic                            i_cfg_vld,
    input  logic                            i_cfg_rdy,
    input  logic [rles_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rles_pkg::CFG_DATA_W-1:0] i_cfg_dat,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_results,
    output int                              o_steps
);
    import rles_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       stepped;
    } t_duty_beat;

    t_duty_beat expected_duties [$];

    logic [2:0]  r_mode;
    logic [3:0]  r_base;
    logic [15:0] r_period;
    logic [15:0] r_ticks;
    logic [7:0]  r_ramp;
    logic        r_up;
    logic        r_low;
    logic [3:0]  r_color;
    logic [7:0]  r_bright;

    int misses;
    int results;
    int steps;

    function automatic int hue_pct(input logic [3:0] color, input int ch);
        logic [23:0] row;
        case (color)
            4'd1:    row = {8'd100, 8'd0,   8'd0};
            4'd2:    row = {8'd100, 8'd15,  8'd0};
            4'd3:    row = {8'd100, 8'd50,  8'd0};
            4'd4:    row = {8'd0,   8'd100, 8'd0};
            4'd5:    row = {8'd0,   8'd100, 8'd100};
            4'd6:    row = {8'd0,   8'd0,   8'd100};
            4'd7:    row = {8'd100, 8'd0,   8'd100};
            4'd8:    row = {8'd100, 8'd100, 8'd100};
            default: row = '0;
        endcase
        return int'(row[23 - 8*ch -: 8]);
    endfunction

    function automatic logic [7:0] duty_of(input int ch);
        int duty;
        duty = hue_pct(r_color, ch) * int'(r_bright) / 100;
        if (duty > 255) duty = 255;
        return 8'(duty);
    endfunction

    function automatic bit field_ok(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
        if (got === want) return 1'b1;
        $error("%s: expected %0d, got %0d", name, want, got);
        return 1'b0;
    endfunction

    task automatic advance_effect(input logic tv, output t_duty_beat beat);
        int span;
        int nxt;
        int delta;
        int r;
        beat.stepped = 1'b0;
        if (tv) begin
            span = int'(r_period);
            if (r_mode == MODE_CYCLE || r_mode == MODE_BREATHE) span = span / STEP_DIVISOR;
            nxt = int'(r_ticks) + 1;
            if (nxt >= span) begin
                r_ticks = '0;
                beat.stepped = 1'b1;
                delta = MAX_BRIGHT / STEP_DIVISOR;
                case (r_mode)
                    MODE_SINGLE: r_bright = 8'(MAX_BRIGHT);
                    MODE_BLINK: begin
                        r_up = ~r_up;
                        r_ramp = r_up ? 8'(MAX_BRIGHT) : 8'd0;
                        r_bright = r_ramp;
                    end
                    MODE_CYCLE, MODE_BREATHE: begin
                        r = int'(r_ramp);
                        if (r >= MAX_BRIGHT) begin
                            r_up = 1'b0;
                            r = MAX_BRIGHT;
                        end else if (r <= MIN_BRIGHT) begin
                            r_up = 1'b1;
                            r = MIN_BRIGHT;
                            r_low = 1'b1;
                        end
                        if (r_up) begin
                            r = r + delta;
                            if (r > 255) r = 255;
                        end else if (r >= MIN_BRIGHT + delta) begin
                            r = r - delta;
                        end else begin
                            r = MIN_BRIGHT;
                        end
                        r_ramp = 8'(r);
                        if (r_mode == MODE_CYCLE) begin
                            if (r_low && r_up) begin
                                r_low = 1'b0;
                                r_color = r_color + 4'd1;
                            end
                            r_color = 4'(int'(r_color) % CYCLE_COLORS);
                            if (r_color == 4'd0) r_color = 4'd1;
                        end
                        r_bright = r_ramp;
                    end
                    default: begin
                        r_color = '0;
                        r_bright = '0;
                    end
                endcase
            end else begin
                r_ticks = 16'(nxt);
            end
        end
        beat.red = duty_of(0);
        beat.green = duty_of(1);
        beat.blue = duty_of(2);
    endtask

    always @(posedge i_clk) begin : watch
        t_duty_beat want;
        t_duty_beat got;
        if (!i_rst_n) begin
            expected_duties.delete();
            r_mode = '0;
            r_base = '0;
            r_period = '0;
            r_ticks = '0;
            r_ramp = '0;
            r_up = 1'b0;
            r_low = 1'b0;
            r_color = '0;
            r_bright = '0;
            misses = 0;
            results = 0;
            steps = 0;
        end else begin
            if (i_res_vld && i_res_rdy) begin
                got = {i_red, i_green, i_blue, i_stepped};
                results++;
                if (i_stepped) steps++;
                if (expected_duties.size() == 0) begin
                    $error("result beat with no expected duties waiting");
                    misses++;
                end else begin
                    want = expected_duties.pop_front();
                    if (!field_ok("red_duty", want.red, got.red)) misses++;
                    if (!field_ok("green_duty", want.green, got.green)) misses++;
                    if (!field_ok("blue_duty", want.blue, got.blue)) misses++;
                    if (!field_ok("stepped", 8'(want.stepped), 8'(got.stepped))) misses++;
                end
            end
            if (i_cfg_vld && i_cfg_rdy) begin
                case (i_cfg_idx)
                    CFG_MODE:   r_mode = i_cfg_dat[2:0];
                    CFG_COLOR: begin
                        r_base = i_cfg_dat[3:0];
                        r_color = r_base;
                    end
                    CFG_PERIOD: r_period = i_cfg_dat;
                    default: ;
                endcase
            end
            if (i_tick_vld && i_tick_rdy) begin
                advance_effect(i_tick, want);
                expected_duties.push_back(want);
            end
        end
        o_pending    <= expected_duties.size();
        o_fail_count <= misses;
        o_results    <= results;
        o_steps      <= steps;
    end

endmodule

/* test/tb_rgb_light_effect_sequencer.sv */
`timescale 1ns / 1ps

module tb_rgb_light_effect_sequencer;
    import rles_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_LEN     = 240;
    localparam int RANDOM_TICKS = 1900;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_tick_valid;
    logic                  o_valid;
    logic                  i_ready;
    logic [7:0]            o_red_duty;
    logic [7:0]            o_green_duty;
    logic [7:0]            o_blue_duty;
    logic                  o_stepped;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int results_seen;
    int steps_seen;
    int ticks_sent = 0;
    int writes_done = 0;
    int quiet = 0;
    int src_idle_pct = 32;
    int snk_idle_pct = 50;
    int hold_token = 0;

    wire any_beat = (i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready);

    rgb_light_effect_sequencer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_tick_valid (i_tick_valid),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red_duty   (o_red_duty),
        .o_green_duty (o_green_duty),
        .o_blue_duty  (o_blue_duty),
        .o_stepped    (o_stepped),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    rles_duty_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_vld   (i_valid),
        .i_tick_rdy   (o_ready),
        .i_tick       (i_tick_valid),
        .i_res_vld    (o_valid),
        .i_res_rdy    (i_ready),
        .i_red        (o_red_duty),
        .i_green      (o_green_duty),
        .i_blue       (o_blue_duty),
        .i_stepped    (o_stepped),
        .i_cfg_vld    (i_cfg_valid),
        .i_cfg_rdy    (o_cfg_ready),
        .i_cfg_idx    (i_cfg_index),
        .i_cfg_dat    (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results_seen),
        .o_steps      (steps_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || any_beat) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("tb_rgb_light_effect_sequencer: errors");
                $finish;
            end
        end
    end

    initial begin : sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (hold_seen != hold_token) begin
                hold_seen = hold_token;
                hold_left = HOLD_LEN;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    task automatic send_tick(input logic tv);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_tick_valid <= tv;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        writes_done++;
        @(negedge i_clk);
    endtask

    task automatic set_effect(input logic [15:0] mode_w, input logic [15:0] color_w,
                              input logic [15:0] period_w, input logic [3:0] mask);
        drain();
        if (mask[0]) cfg_write(CFG_MODE, mode_w);
        if (mask[1]) cfg_write(CFG_COLOR, color_w);
        if (mask[2]) cfg_write(CFG_PERIOD, period_w);
        if (mask[3]) cfg_write(CFG_SPARE, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [15:0] mode_w;
        logic [15:0] color_w;
        logic [15:0] period_w;
        logic [3:0]  mask;
        int          sel;
        int          len;
        int          sent;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_tick_valid = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_tick(1'b1);
        send_tick(1'b0);
        set_effect(16'hFFF8 | 16'(MODE_SINGLE), 16'd1, 16'd0, 4'b0111);
        send_tick(1'b1);
        send_tick(1'b1);
        set_effect(16'(MODE_BLINK), 16'hFFF8, 16'd1, 4'b0111);
        repeat (3) send_tick(1'b1);
        set_effect(16'(MODE_BREATHE), 16'hFFF2, 16'd0, 4'b0111);
        repeat (3) send_tick(1'b1);
        send_tick(1'b0);
        // hold the breathe ramp and walk the colour past the top of the cycle
        set_effect(16'(MODE_CYCLE), 16'd7, 16'd0, 4'b0011);
        repeat (3) send_tick(1'b1);
        set_effect(16'(MODE_SINGLE), 16'd15, 16'd0, 4'b0011);
        send_tick(1'b1);
        set_effect(16'd7, 16'd8, 16'd0, 4'b1011);
        send_tick(1'b1);
        send_tick(1'b0);
        set_effect(16'(MODE_BREATHE), 16'd4, 16'hFFFF, 4'b0111);
        send_tick(1'b1);
        send_tick(1'b1);

        // fill the block behind a long receiver stall, then pause until drained
        set_effect(16'(MODE_BREATHE), 16'd5, 16'd0, 4'b0111);
        src_idle_pct = 0;
        hold_token <= hold_token + 1;
        repeat (30) send_tick($urandom_range(99) < 85);
        drain();
        repeat (10) send_tick($urandom_range(99) < 85);

        sent = 0;
        while (sent < RANDOM_TICKS) begin
            if (sent < RANDOM_TICKS / 3) begin
                src_idle_pct = 32;
                snk_idle_pct <= 50;
            end else if (sent < 2 * RANDOM_TICKS / 3) begin
                src_idle_pct = 50;
                snk_idle_pct <= 32;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct <= 0;
            end
            sel = $urandom_range(99);
            mode_w = 16'($urandom) & 16'hFFF8;
            if (sel < 10) mode_w = mode_w | 16'($urandom_range(7, 5));
            else mode_w = mode_w | 16'($urandom_range(4, 0));
            color_w = 16'($urandom) & 16'hFFF0;
            if ($urandom_range(99) < 12) color_w = color_w | 16'($urandom_range(15, 9));
            else color_w = color_w | 16'($urandom_range(8, 0));
            sel = $urandom_range(99);
            if (sel < 55) period_w = 16'($urandom_range(8));
            else if (sel < 85) period_w = 16'($urandom_range(120, 9));
            else if (sel < 95) period_w = 16'($urandom_range(3000, 121));
            else if (sel < 98) period_w = 16'hFFFF;
            else period_w = 16'($urandom);
            mask = 4'($urandom) | 4'b0001;
            if ($urandom_range(99) < 80) mask[3] = 1'b0;
            set_effect(mode_w, color_w, period_w, mask);
            len = $urandom_range(150, 10);
            repeat (len) send_tick($urandom_range(99) < 85);
            sent = sent + len;
        end

        drain();
        repeat (8) @(negedge i_clk);
        $display("Drove %0d tick beats and %0d register writes through every effect mode,",
                 ticks_sent, writes_done);
        $display("checked %0d result beats, %0d of which stepped the effect.",
                 results_seen, steps_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_rgb_light_effect_sequencer: clean");
        end else begin
            $display("tb_rgb_light_effect_sequencer: errors");
        end
        $finish;
    end

endmodule
